/* src/arpc_pkg.sv */
// Shared types and constants for the ARP cache with aging.
// Used by arpc_ctrl, arpc_dp and arp_cache_with_aging.
package arpc_pkg;

  localparam logic [1:0] MARK_FREE    = 2'd0;
  localparam logic [1:0] MARK_WAITING = 2'd2;
  localparam logic [1:0] MARK_INUSE   = 2'd3;

  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_STORED  = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [63:0] DEFAULT_TIMEOUT = 64'd14400 * 64'd1000000000;

  // scan kinds run by the datapath
  localparam logic [2:0] SCAN_MATCH_WAIT = 3'd0;
  localparam logic [2:0] SCAN_MATCH_USE  = 3'd1;
  localparam logic [2:0] SCAN_FREE       = 3'd2;
  localparam logic [2:0] SCAN_AGE        = 3'd3;
  localparam logic [2:0] SCAN_OLDEST     = 3'd4;

  typedef struct packed {
    logic       load;       // capture input item
    logic       scan_start; // begin a table sweep
    logic [2:0] scan_kind;
    logic       fin_resp;   // finish response
    logic       fin_hit;    // lookup hit
    logic       fin_miss;   // lookup miss, write victim
    logic       use_found;  // victim is scan result (else fallback)
    logic       clear_go;   // start clear pass
  } arpc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic fresh;
    logic act;
    logic aged_ok;   // now >= timeout
    logic clear_done;
  } arpc_stat_t;

endpackage

/* src/arp_cache_with_aging.sv */
// ARP cache with aging: top level joining controller and datapath.
// After the accepting edge, a response follows one match sweep, a hit follows the match sweep
// and a read of the matched entry, and a miss can take up to five sequential sweeps.
// One item at a time; busy stays high through the strobe and the next item can be accepted
// in the cycle after it; the receiver cannot stall. Busy stays high after reset while a
// clearing pass empties the table. Depends on arpc_pkg, arpc_ctrl, arpc_dp, arpc_ram.
module arp_cache_with_aging #(
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  input  logic        action,
  input  logic [31:0] ip_addr,
  input  logic [47:0] hw_addr,
  input  logic [63:0] now,
  output logic        done,
  output logic [1:0]  status,
  output logic [47:0] mac_out,
  output logic [7:0]  entry_index
);
  import arpc_pkg::*;

  localparam int AW = $clog2(ENTRIES);

  arpc_cmd_t  cmd;
  arpc_stat_t stat;

  arpc_ctrl u_ctrl (.clk, .rst, .start, .busy, .cmd, .stat);

  arpc_dp #(.ENTRIES(ENTRIES), .AW(AW)) u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_data, .action, .ip_addr,
    .hw_addr, .now, .done, .status, .mac_out, .entry_index
  );
endmodule

/* src/arpc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read.
// No dependencies.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* src/arpc_dp.sv */
// Datapath: entry memories, table sweep, victim choice and result registers.
// Depends on arpc_pkg and arpc_ram.
module arpc_dp #(
  parameter int ENTRIES = 256,
  parameter int AW = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  arpc_pkg::arpc_cmd_t   cmd,
  output arpc_pkg::arpc_stat_t  stat,
  input  logic                  cfg_we,
  input  logic [63:0]           cfg_data,
  input  logic                  action,
  input  logic [31:0]           ip_addr,
  input  logic [47:0]           hw_addr,
  input  logic [63:0]           now,
  output logic                  done,
  output logic [1:0]            status,
  output logic [47:0]           mac_out,
  output logic [7:0]            entry_index
);
  import arpc_pkg::*;

  logic [63:0] timeout;
  logic        act_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  logic [63:0] now_r;
  logic [63:0] limit;
  logic [AW-1:0] fallback;

  // sweep: address counter, then the read data in the cycle after
  logic          scanning, rd_valid, last_issued, rd_last;
  logic [2:0]    kind;
  logic [AW-1:0] addr, rd_addr;
  logic          found;
  logic [AW-1:0] found_idx;
  logic [63:0]   best_time;
  logic          scan_done;

  logic [AW-1:0] clr_addr;
  logic          clearing;

  logic [1:0]  mark_rd;
  logic [31:0] ip_rd;
  logic [47:0] mac_rd;
  logic [63:0] time_rd;

  logic          mark_we, ip_we, mac_we, time_we;
  logic [AW-1:0] waddr;
  logic [1:0]    mark_wd;
  logic [31:0]   ip_wd;
  logic [63:0]   time_wd;
  logic [47:0]   mac_wd;
  logic [AW-1:0] raddr;
  logic          hit_entry;
  logic [AW-1:0] victim;

  assign raddr = scanning ? addr : found_idx;

  always_comb begin
    hit_entry = 1'b0;
    unique case (kind)
      SCAN_MATCH_WAIT: hit_entry = mark_rd == MARK_WAITING && ip_rd == ip_r;
      SCAN_MATCH_USE:  hit_entry = mark_rd == MARK_INUSE && ip_rd == ip_r;
      SCAN_FREE:       hit_entry = mark_rd == MARK_FREE;
      SCAN_OLDEST:     hit_entry = mark_rd == MARK_INUSE &&
                                   (!found || time_rd < best_time);
      default:         hit_entry = 1'b0;
    endcase
  end

  assign victim = cmd.use_found ? found_idx : fallback;

  // memory write selection
  always_comb begin
    mark_we = 1'b0; ip_we = 1'b0; mac_we = 1'b0; time_we = 1'b0;
    waddr = found_idx; mark_wd = MARK_WAITING; ip_wd = ip_r;
    mac_wd = mac_r; time_wd = now_r;
    if (clearing) begin
      waddr = clr_addr; mark_wd = MARK_FREE; ip_wd = '0; mac_wd = '0; time_wd = '0;
      mark_we = 1'b1; ip_we = 1'b1; mac_we = 1'b1; time_we = 1'b1;
    end else if (rd_valid && kind == SCAN_AGE) begin
      waddr = rd_addr; mark_wd = MARK_FREE;
      mark_we = time_rd < limit;
    end else if (cmd.fin_resp && found) begin
      mark_wd = MARK_INUSE; mark_we = 1'b1; mac_we = 1'b1; time_we = 1'b1;
    end else if (cmd.fin_miss) begin
      waddr = victim; mark_we = 1'b1; ip_we = 1'b1;
    end
  end

  arpc_ram #(.WIDTH(2),  .DEPTH(ENTRIES)) u_mark (.clk, .we(mark_we), .waddr,
    .wdata(mark_wd), .raddr, .rdata(mark_rd));
  arpc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ip (.clk, .we(ip_we), .waddr,
    .wdata(ip_wd), .raddr, .rdata(ip_rd));
  arpc_ram #(.WIDTH(48), .DEPTH(ENTRIES)) u_mac (.clk, .we(mac_we), .waddr,
    .wdata(mac_wd), .raddr, .rdata(mac_rd));
  arpc_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_time (.clk, .we(time_we), .waddr,
    .wdata(time_wd), .raddr, .rdata(time_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= DEFAULT_TIMEOUT;
      fallback <= '0;
      scanning <= 1'b0;
      rd_valid <= 1'b0;
      scan_done <= 1'b0;
      clearing <= 1'b0;
      clr_addr <= '0;
      done <= 1'b0;
      found <= 1'b0;
    end else begin
      if (cfg_we) timeout <= cfg_data;
      // registered from now_r, so it settles well before the first sweep reads it
      limit <= now_r - timeout;
      done <= 1'b0;
      scan_done <= 1'b0;
      if (cmd.clear_go) begin
        clearing <= 1'b1;
        clr_addr <= '0;
      end else if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(ENTRIES - 1)) clearing <= 1'b0;
      end
      if (cmd.load) begin
        act_r <= action; ip_r <= ip_addr; mac_r <= hw_addr; now_r <= now;
      end
      if (cmd.scan_start) begin
        scanning <= 1'b1;
        kind <= cmd.scan_kind;
        addr <= '0;
        found <= 1'b0;
        rd_valid <= 1'b0;
      end else begin
        rd_valid <= scanning;
        rd_addr <= addr;
        rd_last <= last_issued;
        if (scanning) begin
          addr <= addr + 1'b1;
          if (addr == AW'(ENTRIES - 1)) scanning <= 1'b0;
        end
        // stop early once a first match is seen, except in the oldest-entry scan, which sweeps every entry
        if (rd_valid && hit_entry) begin
          found <= 1'b1;
          found_idx <= rd_addr;
          best_time <= time_rd;
          if (kind != SCAN_OLDEST) begin
            scanning <= 1'b0;
            rd_valid <= 1'b0;
            scan_done <= 1'b1;
          end
        end
        if (rd_valid && rd_last && !(hit_entry && kind != SCAN_OLDEST))
          scan_done <= 1'b1;
      end
      if (cmd.fin_resp) begin
        done <= 1'b1;
        status <= found ? ST_STORED : ST_IGNORED;
        mac_out <= '0;
        entry_index <= found ? 8'(found_idx) : 8'd0;
      end
      if (cmd.fin_hit) begin
        done <= 1'b1;
        status <= ST_HIT;
        mac_out <= mac_rd;
        entry_index <= 8'(found_idx);
      end
      if (cmd.fin_miss) begin
        done <= 1'b1;
        status <= ST_MISS;
        mac_out <= '0;
        entry_index <= 8'(victim);
        if (!cmd.use_found)
          fallback <= (fallback == AW'(ENTRIES - 1)) ? '0 : fallback + 1'b1;
      end
    end
  end

  assign last_issued = scanning && addr == AW'(ENTRIES - 1);

  assign stat.scan_done  = scan_done;
  assign stat.found      = found;
  assign stat.fresh      = now_r <= timeout || time_rd > limit;
  assign stat.act        = act_r;
  assign stat.aged_ok    = now_r >= timeout;
  assign stat.clear_done = !clearing;
endmodule

/* src/arpc_ctrl.sv */
// Controller: sequences table sweeps for one item at a time.
// Depends on arpc_pkg.
module arpc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output arpc_pkg::arpc_cmd_t  cmd,
  input  arpc_pkg::arpc_stat_t stat
);
  import arpc_pkg::*;

  localparam logic [3:0] S_RST   = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_IDLE  = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_FREE1 = 4'd6;
  localparam logic [3:0] S_AGE   = 4'd7;
  localparam logic [3:0] S_FREE2 = 4'd8;
  localparam logic [3:0] S_OLD   = 4'd9;
  localparam logic [3:0] S_WAIT  = 4'd10;

  logic [3:0] state, state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_RST: begin
        cmd.clear_go = 1'b1;
        state_next = S_CLEAR;
      end
      S_CLEAR: if (stat.clear_done) state_next = S_IDLE;
      S_IDLE: if (start) begin
        cmd.load = 1'b1;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.scan_start = 1'b1;
        cmd.scan_kind = stat.act ? SCAN_MATCH_WAIT : SCAN_MATCH_USE;
        state_next = S_RD;
      end
      S_RD: if (stat.scan_done) begin
        if (stat.act) begin
          cmd.fin_resp = 1'b1;
          state_next = S_WAIT;
        end else if (stat.found) begin
          state_next = S_CHK; // wait for read of the matched entry
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_kind = SCAN_FREE;
          state_next = S_FREE1;
        end
      end
      S_CHK: begin
        if (stat.fresh) cmd.fin_hit = 1'b1;
        else begin
          cmd.fin_miss = 1'b1;
          cmd.use_found = 1'b1;
        end
        state_next = S_WAIT;
      end
      S_FREE1: if (stat.scan_done) begin
        if (stat.found) begin
          cmd.fin_miss = 1'b1;
          cmd.use_found = 1'b1;
          state_next = S_WAIT;
        end else if (stat.aged_ok) begin
          cmd.scan_start = 1'b1;
          cmd.scan_kind = SCAN_AGE;
          state_next = S_AGE;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_kind = SCAN_OLDEST;
          state_next = S_OLD;
        end
      end
      S_AGE: if (stat.scan_done) begin
        cmd.scan_start = 1'b1;
        cmd.scan_kind = SCAN_FREE;
        state_next = S_FREE2;
      end
      S_FREE2: if (stat.scan_done) begin
        if (stat.found) begin
          cmd.fin_miss = 1'b1;
          cmd.use_found = 1'b1;
          state_next = S_WAIT;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_kind = SCAN_OLDEST;
          state_next = S_OLD;
        end
      end
      S_OLD: if (stat.scan_done) begin
        cmd.fin_miss = 1'b1;
        cmd.use_found = stat.found;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = S_IDLE; // let the result write settle
      default: state_next = S_RST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_RST;
    else state <= state_next;
  end
endmodule

/* dv/tb_arp_cache_with_aging.sv */
// Testbench for the ARP cache with aging: lookups and responses against a local table model.
// Depends on arpc_pkg and arp_cache_with_aging.
module tb_arp_cache_with_aging;
  import arpc_pkg::*;

  localparam int N = 256;
  localparam int WD_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [63:0] cfg_data = '0;
  logic action = 1'b0;
  logic [31:0] ip_addr = '0;
  logic [47:0] hw_addr = '0;
  logic [63:0] now = '0;
  logic done;
  logic [1:0] status;
  logic [47:0] mac_out;
  logic [7:0] entry_index;

  arp_cache_with_aging #(.ENTRIES(N)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .action(action), .ip_addr(ip_addr), .hw_addr(hw_addr),
    .now(now), .done(done), .status(status), .mac_out(mac_out),
    .entry_index(entry_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table copy
  logic [1:0]  tbl_mark [N];
  logic [31:0] tbl_ip   [N];
  logic [47:0] tbl_mac  [N];
  logic [63:0] tbl_time [N];
  logic [7:0]  fb_ptr;
  logic [63:0] timeout_q;

  typedef struct packed {
    logic [1:0]  st;
    logic [47:0] mac;
    logic [7:0]  idx;
  } arp_res_t;

  arp_res_t pending_res[$];
  int errors = 0;
  int idle_pct = 0;
  int wd = 0;
  int ip_pool_sz = 8;
  logic [63:0] clock_ns = '0;

  function automatic int find_mark(logic [1:0] m, bit by_ip, logic [31:0] ip);
    for (int i = 0; i < N; i++)
      if (tbl_mark[i] == m && (!by_ip || tbl_ip[i] == ip)) return i;
    return -1;
  endfunction

  function automatic int choose_victim(logic [63:0] t);
    int v;
    v = find_mark(MARK_FREE, 0, '0);
    if (v >= 0) return v;
    if (t >= timeout_q)
      for (int i = 0; i < N; i++)
        if (tbl_time[i] < t - timeout_q) tbl_mark[i] = MARK_FREE;
    v = find_mark(MARK_FREE, 0, '0);
    if (v >= 0) return v;
    for (int i = 0; i < N; i++)
      if (tbl_mark[i] == MARK_INUSE && (v < 0 || tbl_time[i] < tbl_time[v])) v = i;
    if (v >= 0) return v;
    v = int'(fb_ptr);
    fb_ptr = fb_ptr + 8'd1;
    return v;
  endfunction

  function automatic arp_res_t predict_cache(logic a, logic [31:0] ip, logic [47:0] mac,
                                             logic [63:0] t);
    arp_res_t r;
    int k;
    r = '0;
    if (a) begin
      k = find_mark(MARK_WAITING, 1, ip);
      if (k >= 0) begin
        tbl_mac[k] = mac;
        tbl_time[k] = t;
        tbl_mark[k] = MARK_INUSE;
        r.st = ST_STORED;
        r.idx = k[7:0];
      end else begin
        r.st = ST_IGNORED;
      end
    end else begin
      k = find_mark(MARK_INUSE, 1, ip);
      if (k >= 0 && (t <= timeout_q || tbl_time[k] > t - timeout_q)) begin
        r.st = ST_HIT;
        r.mac = tbl_mac[k];
        r.idx = k[7:0];
      end else begin
        if (k < 0) k = choose_victim(t);
        tbl_ip[k] = ip;
        tbl_mark[k] = MARK_WAITING;
        r.st = ST_MISS;
        r.idx = k[7:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result status=%0d mac=%h idx=%0d", $time, status,
                 mac_out, entry_index);
        errors++;
      end else begin
        arp_res_t e;
        e = pending_res.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (mac_out !== e.mac) begin
          $display("%0t: mac_out expected %h actual %h", $time, e.mac, mac_out);
          errors++;
        end
        if (entry_index !== e.idx) begin
          $display("%0t: entry_index expected %0d actual %0d", $time, e.idx, entry_index);
          errors++;
        end
      end
    end
  end

  // watchdog over cycles with no accepted item or result
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) wd <= 0;
    else wd <= wd + 1;
    if (wd >= WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(logic a, logic [31:0] ip, logic [47:0] mac, logic [63:0] t);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) @(posedge clk);
    start <= 1'b1;
    action <= a;
    ip_addr <= ip;
    hw_addr <= mac;
    now <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_res.push_back(predict_cache(a, ip, mac, t));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_timeout(logic [63:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_q = v;
  endtask

  function automatic logic [31:0] pool_ip();
    return 32'hC0A8_0000 + $urandom_range(ip_pool_sz - 1, 0);
  endfunction

  task automatic test_directed();
    send_item(1'b0, 32'h0000_0000, '0, 64'd0);
    send_item(1'b1, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 64'd5);
    send_item(1'b0, 32'h0000_0000, '0, 64'd10);
    send_item(1'b1, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 64'd11);
    send_item(1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'd12);
    send_item(1'b1, 32'hFFFF_FFFF, 48'hAAAA_5555_AAAA, 64'd13);
    send_item(1'b0, 32'hFFFF_FFFF, '0, 64'd14);
    send_item(1'b1, 32'hFFFF_FFFF, 48'h0, 64'd15);
    send_item(1'b0, 32'h0000_0000, '0, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // stale hit and aging with a short timeout
  task automatic test_aging();
    write_timeout(64'd100);
    send_item(1'b0, 32'h0A00_0001, '0, 64'd1000);
    send_item(1'b1, 32'h0A00_0001, 48'h0000_0000_0001, 64'd1000);
    send_item(1'b0, 32'h0A00_0001, '0, 64'd1050);
    send_item(1'b0, 32'h0A00_0001, '0, 64'd1200);
    send_item(1'b1, 32'h0A00_0001, 48'h0000_0000_0002, 64'd1201);
    send_item(1'b0, 32'h0A00_0001, '0, 64'd1301);
    send_item(1'b0, 32'h0A00_0001, '0, 64'd1302);
  endtask

  // fill table so victim choice runs aging, oldest in use and fallback pointer
  task automatic test_full_table();
    write_timeout(64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < N + 4; i++) begin
      send_item(1'b0, 32'h5000_0000 + i, '0, 64'd2000 + i);
      if (i % 2 == 0)
        send_item(1'b1, 32'h5000_0000 + i, 48'({$urandom, $urandom}), 64'd3000 - i);
    end
    // enough misses to use up every in-use entry and reach the fallback pointer
    for (int i = 0; i < N / 2 + 16; i++)
      send_item(1'b0, 32'h6000_0000 + i, '0, 64'd4000 + i);
    write_timeout(64'd0);
    send_item(1'b0, 32'h7000_0000, '0, 64'd5000);
  endtask

  task automatic test_random(int count);
    logic [63:0] t;
    int phase_len;
    phase_len = count / 4;
    for (int i = 0; i < count; i++) begin
      if (i % phase_len == 0)
        idle_pct = (i / phase_len) % 4 == 1 ? 53 : ((i / phase_len) % 4 == 3 ? 25 : 0);
      if (i == count / 2) begin
        drain_results();
        write_timeout($urandom_range(3) == 0 ? 64'd0 : 64'd50 + $urandom_range(400));
        ip_pool_sz = 300;
      end
      clock_ns = clock_ns + $urandom_range(20);
      t = clock_ns;
      if ($urandom_range(19) == 0) t = {$urandom, $urandom};
      case ($urandom_range(9))
        0: send_item(1'b0, $urandom, 48'({$urandom, $urandom}), t);
        1: send_item(1'b1, $urandom, 48'({$urandom, $urandom}), t);
        2, 3, 4, 5: send_item(1'b0, pool_ip(), 48'({$urandom, $urandom}), t);
        default: send_item(1'b1, pool_ip(), 48'({$urandom, $urandom}), t);
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < N; i++) begin
      tbl_mark[i] = MARK_FREE;
      tbl_ip[i] = '0;
      tbl_mac[i] = '0;
      tbl_time[i] = '0;
    end
    fb_ptr = '0;
    timeout_q = DEFAULT_TIMEOUT;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_aging();
    test_full_table();
    write_timeout(64'd300);
    clock_ns = 64'd10000;
    test_random(260);
    drain_results();
    repeat (1200) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
